/* hw/rtl/rb85_pkg.sv */
// rb85_pkg: shared types, constants and alphabet functions of the rotating base-85 codec.
// Used by every module of the codec; depends on nothing else.
`default_nettype none

package rb85_pkg;

	// configuration register indexes and mode codes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP = 1'b1;
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic [6:0] RADIX = 7'd85;
	localparam logic [2:0] ENC_GROUP = 3'd4;
	localparam logic [2:0] DEC_GROUP = 3'd5;
	localparam logic [2:0] ENC_SYMBOLS = 3'd5;
	localparam logic [2:0] DEC_BYTES = 3'd4;

	// floor(v / 85) = (v * DIV85_MAGIC) >> DIV85_SHIFT for every 32-bit v
	localparam logic [31:0] DIV85_MAGIC = 32'd3233857729;
	localparam int DIV85_SHIFT = 38;

	typedef struct packed {
		logic [7:0] in_value;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_value;
		logic       out_last;
	} out_item_t;

	// one finished group: padded word (encode) or decoded word
	typedef struct packed {
		logic [31:0] value;
		logic        last;
	} tok_t;

	// digits or bytes ready to go out, entry 0 first
	typedef struct packed {
		logic [4:0][7:0] dig;
		logic            last;
	} batch_t;

	// (a + b) mod 85 for a, b below 85
	function automatic logic [6:0] add_mod85(input logic [6:0] a, input logic [6:0] b);
		logic [7:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, RADIX}) begin
			s = s - {1'b0, RADIX};
		end
		return s[6:0];
	endfunction

	// (d - o) mod 85 for d, o below 85
	function automatic logic [6:0] sub_mod85(input logic [6:0] d, input logic [6:0] o);
		logic [7:0] s;
		if (d >= o) begin
			s = {1'b0, d} - {1'b0, o};
		end else begin
			s = {1'b0, d} + {1'b0, RADIX} - {1'b0, o};
		end
		return s[6:0];
	endfunction

	// alphabet index to character code
	function automatic logic [7:0] index_to_char(input logic [6:0] i);
		logic [7:0] c;
		c = 8'd0;
		if (i < 7'd10) begin
			c = 8'd48 + {1'b0, i};
		end else if (i < 7'd36) begin
			c = 8'd87 + {1'b0, i};
		end else if (i < 7'd62) begin
			c = 8'd29 + {1'b0, i};
		end else begin
			case (i)
				7'd62: c = 8'd46;   // .
				7'd63: c = 8'd45;   // -
				7'd64: c = 8'd58;   // :
				7'd65: c = 8'd43;   // +
				7'd66: c = 8'd61;   // =
				7'd67: c = 8'd94;   // ^
				7'd68: c = 8'd33;   // !
				7'd69: c = 8'd47;   // /
				7'd70: c = 8'd42;   // *
				7'd71: c = 8'd63;   // ?
				7'd72: c = 8'd38;   // &
				7'd73: c = 8'd60;   // <
				7'd74: c = 8'd62;   // >
				7'd75: c = 8'd40;   // (
				7'd76: c = 8'd41;   // )
				7'd77: c = 8'd91;   // [
				7'd78: c = 8'd93;   // ]
				7'd79: c = 8'd123;  // {
				7'd80: c = 8'd125;  // }
				7'd81: c = 8'd64;   // @
				7'd82: c = 8'd37;   // %
				7'd83: c = 8'd36;   // $
				7'd84: c = 8'd35;   // #
				default: c = 8'd0;
			endcase
		end
		return c;
	endfunction

	// character code to alphabet index, unknown characters give 0
	function automatic logic [6:0] char_to_index(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= 8'd48 && c <= 8'd57) begin
			t = c - 8'd48;
		end else if (c >= 8'd97 && c <= 8'd122) begin
			t = c - 8'd87;
		end else if (c >= 8'd65 && c <= 8'd90) begin
			t = c - 8'd29;
		end else begin
			case (c)
				8'd46:   t = 8'd62;
				8'd45:   t = 8'd63;
				8'd58:   t = 8'd64;
				8'd43:   t = 8'd65;
				8'd61:   t = 8'd66;
				8'd94:   t = 8'd67;
				8'd33:   t = 8'd68;
				8'd47:   t = 8'd69;
				8'd42:   t = 8'd70;
				8'd63:   t = 8'd71;
				8'd38:   t = 8'd72;
				8'd60:   t = 8'd73;
				8'd62:   t = 8'd74;
				8'd40:   t = 8'd75;
				8'd41:   t = 8'd76;
				8'd91:   t = 8'd77;
				8'd93:   t = 8'd78;
				8'd123:  t = 8'd79;
				8'd125:  t = 8'd80;
				8'd64:   t = 8'd81;
				8'd37:   t = 8'd82;
				8'd36:   t = 8'd83;
				8'd35:   t = 8'd84;
				default: t = 8'd0;
			endcase
		end
		return t[6:0];
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/rotating_base85_codec.sv */
// Rotating base-85 codec, top level: configuration registers and the three stages.
// Order: input register, group register, 5-step divide-by-85 unit (encode only), batch
// register, serializer buffer, output register. Within a batch results leave 1 per cycle
// while out_stall is low. The divider takes no new group until done; decode takes one
// character per cycle unless stalled. Reset clears all stream state; mode encode, step 0.
// Depends on rb85_pkg, rb85_front, rb85_conv, rb85_emit.
`default_nettype none

module rotating_base85_codec (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire rb85_pkg::in_item_t               in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output rb85_pkg::out_item_t                   out_data,
	input  wire logic                             cfg_we,
	input  wire logic [rb85_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [6:0]                       cfg_data
);

	logic             mode_q;
	logic [6:0]       step_q;
	logic             clear;
	logic             tok_valid;
	logic             tok_ready;
	rb85_pkg::tok_t   tok;
	logic             batch_valid;
	logic             batch_ready;
	rb85_pkg::batch_t batch;

	assign clear = cfg_we && (cfg_index == rb85_pkg::REG_MODE);

	// configuration registers, step kept reduced mod 85
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rb85_pkg::MODE_ENCODE;
			step_q <= 7'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				rb85_pkg::REG_MODE: mode_q <= cfg_data[0];
				rb85_pkg::REG_STEP: begin
					step_q <= (cfg_data >= rb85_pkg::RADIX) ? cfg_data - rb85_pkg::RADIX
					                                        : cfg_data;
				end
				default: step_q <= step_q;
			endcase
		end
	end

	rb85_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear),
		.mode      (mode_q),
		.step      (step_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok)
	);

	rb85_conv u_conv (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode_q),
		.tok_valid   (tok_valid),
		.tok_ready   (tok_ready),
		.tok         (tok),
		.batch_valid (batch_valid),
		.batch_ready (batch_ready),
		.batch       (batch)
	);

	rb85_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (clear),
		.mode        (mode_q),
		.step        (step_q),
		.batch_valid (batch_valid),
		.batch_ready (batch_ready),
		.batch       (batch),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

/* hw/rtl/rb85_front.sv */
// rb85_front: input register and stream state; packs bytes (encode) or accumulates
// rotated digits (decode) and hands finished groups on. Depends on rb85_pkg.
`default_nettype none

module rb85_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clear,
	input  wire logic              mode,
	input  wire logic [6:0]        step,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire rb85_pkg::in_item_t in_data,
	output logic                   tok_valid,
	input  wire logic              tok_ready,
	output rb85_pkg::tok_t         tok
);

	logic               valid_s1;
	rb85_pkg::in_item_t item_s1;
	logic [31:0]        grp_q;
	logic [2:0]         cnt_q;
	logic [6:0]         off_q;
	logic               tok_valid_q;
	rb85_pkg::tok_t     tok_q;

	logic [2:0]  cnt_next;
	logic [31:0] enc_word;
	logic [31:0] enc_pad;
	logic [6:0]  dec_digit;
	logic [31:0] dec_word;
	logic        complete;
	logic        produce;
	logic        s1_done;
	logic        step_go;
	logic        in_xfer;

	// group building for the item held in the input register
	always_comb begin
		cnt_next  = cnt_q + 3'd1;
		enc_word  = {grp_q[23:0], item_s1.in_value};
		dec_digit = rb85_pkg::add_mod85(rb85_pkg::char_to_index(item_s1.in_value), off_q);
		dec_word  = (grp_q << 6) + (grp_q << 4) + (grp_q << 2) + grp_q + {25'd0, dec_digit};
		case (cnt_next)
			3'd1:    enc_pad = {enc_word[7:0], 24'd0};
			3'd2:    enc_pad = {enc_word[15:0], 16'd0};
			3'd3:    enc_pad = {enc_word[23:0], 8'd0};
			default: enc_pad = enc_word;
		endcase
		if (mode == rb85_pkg::MODE_ENCODE) begin
			complete = (cnt_next == rb85_pkg::ENC_GROUP) || item_s1.in_last;
		end else begin
			complete = (cnt_next == rb85_pkg::DEC_GROUP);
		end
		produce  = valid_s1 && complete;
		s1_done  = !produce || !tok_valid_q || tok_ready;
		step_go  = valid_s1 && s1_done;
		in_stall = valid_s1 && !s1_done;
		in_xfer  = in_valid && !in_stall;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_data;
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= 32'd0;
			cnt_q <= 3'd0;
			off_q <= 7'd0;
		end else if (clear) begin
			grp_q <= 32'd0;
			cnt_q <= 3'd0;
			off_q <= 7'd0;
		end else if (step_go) begin
			if (item_s1.in_last) begin
				grp_q <= 32'd0;
				cnt_q <= 3'd0;
				off_q <= 7'd0;
			end else begin
				if (complete) begin
					grp_q <= 32'd0;
					cnt_q <= 3'd0;
				end else begin
					grp_q <= (mode == rb85_pkg::MODE_ENCODE) ? enc_word : dec_word;
					cnt_q <= cnt_next;
				end
				if (mode == rb85_pkg::MODE_DECODE) begin
					off_q <= rb85_pkg::add_mod85(off_q, step);
				end
			end
		end
	end

	// group register toward the converter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (produce && s1_done) begin
			tok_valid_q <= 1'b1;
		end else if (tok_ready) begin
			tok_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce && s1_done) begin
			tok_q.value <= (mode == rb85_pkg::MODE_ENCODE) ? enc_pad : dec_word;
			tok_q.last  <= item_s1.in_last;
		end
	end

	assign tok_valid = tok_valid_q;
	assign tok       = tok_q;

`ifndef SYNTHESIS
	// a group never holds more items than it takes to complete it
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < rb85_pkg::DEC_GROUP)
		else $error("front group count out of range");
	// decode offset stays a residue mod 85
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		off_q < rb85_pkg::RADIX)
		else $error("front offset out of range");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rb85_conv.sv */
// rb85_conv: splits an encode group into five base-85 digits, one division by 85
// per cycle, or unpacks a decoded word into four bytes. Depends on rb85_pkg.
`default_nettype none

module rb85_conv (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           mode,
	input  wire logic           tok_valid,
	output logic                tok_ready,
	input  wire rb85_pkg::tok_t tok,
	output logic                batch_valid,
	input  wire logic           batch_ready,
	output rb85_pkg::batch_t    batch
);

	logic             busy_q;
	logic             full_q;
	logic [2:0]       step_q;
	logic [31:0]      val_q;
	rb85_pkg::batch_t batch_q;

	logic        tok_xfer;
	logic        batch_xfer;
	logic        last_step;
	logic [9:0]  byte_sum;
	logic [8:0]  fold;
	logic [8:0]  rem;
	logic [63:0] prod;
	logic [31:0] quot;

	// v mod 85 from the byte sum (256 is 1 mod 85), v / 85 by reciprocal
	always_comb begin
		byte_sum = {2'd0, val_q[7:0]} + {2'd0, val_q[15:8]}
		         + {2'd0, val_q[23:16]} + {2'd0, val_q[31:24]};
		fold = {1'b0, byte_sum[7:0]} + {7'd0, byte_sum[9:8]};
		if (fold >= 9'd255) begin
			rem = fold - 9'd255;
		end else if (fold >= 9'd170) begin
			rem = fold - 9'd170;
		end else if (fold >= 9'd85) begin
			rem = fold - 9'd85;
		end else begin
			rem = fold;
		end
		prod = {32'd0, val_q} * {32'd0, rb85_pkg::DIV85_MAGIC};
		quot = {6'd0, prod[63:rb85_pkg::DIV85_SHIFT]};
	end

	assign tok_ready   = !busy_q && (!full_q || batch_ready);
	assign tok_xfer    = tok_valid && tok_ready;
	assign batch_xfer  = full_q && batch_ready;
	assign last_step   = busy_q && (step_q == rb85_pkg::ENC_SYMBOLS - 3'd1);
	assign batch_valid = full_q;
	assign batch       = batch_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			full_q <= 1'b0;
			step_q <= 3'd0;
		end else begin
			if (tok_xfer && mode == rb85_pkg::MODE_ENCODE) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (last_step) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
			end
			if ((tok_xfer && mode == rb85_pkg::MODE_DECODE) || last_step) begin
				full_q <= 1'b1;
			end else if (batch_xfer) begin
				full_q <= 1'b0;
			end
		end
	end

	// digit shift register, most significant digit ends in entry 0
	always_ff @(posedge clk) begin
		if (tok_xfer) begin
			val_q        <= tok.value;
			batch_q.last <= tok.last;
			if (mode == rb85_pkg::MODE_DECODE) begin
				batch_q.dig <= {8'd0, tok.value[7:0], tok.value[15:8],
				                tok.value[23:16], tok.value[31:24]};
			end
		end else if (busy_q) begin
			val_q       <= quot;
			batch_q.dig <= {batch_q.dig[3:0], 1'b0, rem[6:0]};
		end
	end

`ifndef SYNTHESIS
	// a batch is never offered while its digits are still being formed
	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && full_q))
		else $error("converter offers a batch while busy");
	// the step counter stops at the fifth digit
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q < rb85_pkg::ENC_SYMBOLS))
		else $error("converter step out of range");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rb85_emit.sv */
// rb85_emit: serializes a batch into the output register, rotating and mapping
// encode digits to alphabet characters. Depends on rb85_pkg.
`default_nettype none

module rb85_emit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clear,
	input  wire logic             mode,
	input  wire logic [6:0]       step,
	input  wire logic             batch_valid,
	output logic                  batch_ready,
	input  wire rb85_pkg::batch_t batch,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output rb85_pkg::out_item_t   out_data
);

	logic                act_q;
	logic [2:0]          idx_q;
	logic [6:0]          off_q;
	rb85_pkg::batch_t    buf_q;
	logic                out_valid_q;
	rb85_pkg::out_item_t out_q;

	logic       slot_free;
	logic       emit;
	logic       final_item;
	logic       take;
	logic [2:0] last_idx;
	logic [6:0] sym;
	logic [7:0] value;

	// next result out of the held batch
	always_comb begin
		last_idx   = ((mode == rb85_pkg::MODE_DECODE) ? rb85_pkg::DEC_BYTES
		                                               : rb85_pkg::ENC_SYMBOLS) - 3'd1;
		slot_free  = !out_valid_q || !out_stall;
		emit       = act_q && slot_free;
		final_item = idx_q == last_idx;
		sym        = rb85_pkg::sub_mod85(buf_q.dig[0][6:0], off_q);
		if (mode == rb85_pkg::MODE_ENCODE) begin
			value = rb85_pkg::index_to_char(sym);
		end else begin
			value = buf_q.dig[0];
		end
		batch_ready = !act_q || (emit && final_item);
		take        = batch_valid && batch_ready;
	end

	// serializer control and symbol offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= 3'd0;
			off_q <= 7'd0;
		end else begin
			if (take) begin
				act_q <= 1'b1;
				idx_q <= 3'd0;
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
				if (final_item) begin
					act_q <= 1'b0;
				end
			end
			if (clear) begin
				off_q <= 7'd0;
			end else if (emit && mode == rb85_pkg::MODE_ENCODE) begin
				if (final_item && buf_q.last) begin
					off_q <= 7'd0;
				end else begin
					off_q <= rb85_pkg::add_mod85(off_q, step);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q <= batch;
		end else if (emit) begin
			buf_q.dig <= {8'd0, buf_q.dig[4:1]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (slot_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_value <= value;
			out_q.out_last  <= final_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// the serializer never runs past the end of a batch
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> (idx_q <= last_idx))
		else $error("emitter index past end of batch");
	// encode offset stays a residue mod 85
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		off_q < rb85_pkg::RADIX)
		else $error("emitter offset out of range");
`endif

endmodule

`default_nettype wire

/* test/testbench.sv */
// testbench: self-checking regression for rotating_base85_codec, encode and decode with rotation.
// Predicts every symbol or byte from its own codec model and checks each output transfer.
// Depends on rb85_pkg and rotating_base85_codec.
`timescale 1ns / 1ps

module testbench;

	localparam int TOTAL_ITEMS = 270;
	localparam int SETTLE_CYCLES = 24;
	localparam int STUCK_LIMIT = 2000;
	localparam int unsigned Z_BASE = 85;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	rb85_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rb85_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [rb85_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;

	// symbol set, index order
	string z85_set = {"0123456789abcdefghijklmnopqrstuvwxyz",
		"ABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#"};

	// codec model state and registers
	logic cur_mode = rb85_pkg::MODE_ENCODE;
	int unsigned cur_step = 0;
	int unsigned grp_len = 0;
	int unsigned grp_word = 0;
	int unsigned rot_ofs = 0;

	rb85_pkg::out_item_t owed_octets[$];

	int n_sent = 0;
	int n_checked = 0;
	int n_settings = 0;
	int n_err = 0;
	int in_gap_pct = 0;
	int out_stall_pct = 0;
	int next_gap = 0;
	int stall_left = 0;

	rotating_base85_codec i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle length: nonzero with probability pct percent; then mostly short, a few long
	function automatic int idle_len(int pct);
		if ($urandom_range(99) >= pct) begin
			return 0;
		end
		if ($urandom_range(9) == 0) begin
			return $urandom_range(40, 10);
		end
		return $urandom_range(3, 1);
	endfunction

	function automatic int unsigned z85_index(logic [7:0] c);
		for (int k = 0; k < Z_BASE; k++) begin
			if (z85_set[k] == c) begin
				return k;
			end
		end
		return 0;
	endfunction

	function automatic void clear_stream();
		grp_len = 0;
		grp_word = 0;
		rot_ofs = 0;
	endfunction

	function automatic void step_offset();
		rot_ofs = (rot_ofs + cur_step % Z_BASE) % Z_BASE;
	endfunction

	// fold one accepted item into the model and queue the octets it owes
	function automatic void absorb_item(rb85_pkg::in_item_t it);
		int unsigned w;
		int unsigned dig[5];
		int unsigned sym;
		rb85_pkg::out_item_t o;
		if (cur_mode == rb85_pkg::MODE_ENCODE) begin
			grp_word = (grp_word << 8) | it.in_value;
			grp_len++;
			if (grp_len == 4 || it.in_last) begin
				w = grp_word << (8 * (4 - grp_len));
				for (int k = 4; k >= 0; k--) begin
					dig[k] = w % Z_BASE;
					w = w / Z_BASE;
				end
				for (int k = 0; k < 5; k++) begin
					sym = (dig[k] + Z_BASE - rot_ofs) % Z_BASE;
					o.out_value = z85_set[sym];
					o.out_last = (k == 4);
					owed_octets.insert(owed_octets.size(), o);
					step_offset();
				end
				grp_len = 0;
				grp_word = 0;
			end
		end else begin
			sym = (z85_index(it.in_value) + rot_ofs) % Z_BASE;
			step_offset();
			grp_word = grp_word * Z_BASE + sym;
			grp_len++;
			if (grp_len == 5) begin
				for (int k = 0; k < 4; k++) begin
					o.out_value = grp_word[31 - 8 * k -: 8];
					o.out_last = (k == 3);
					owed_octets.insert(owed_octets.size(), o);
				end
				grp_len = 0;
				grp_word = 0;
			end
		end
		if (it.in_last) begin
			clear_stream();
		end
	endfunction

	// one input transfer; valid stays high only when the next item follows at once
	task automatic send_item(logic [7:0] value, bit ends_stream, bit more);
		rb85_pkg::in_item_t it;
		it.in_value = value;
		it.in_last = ends_stream;
		if (next_gap > 0) begin
			repeat (next_gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		absorb_item(it);
		n_sent++;
		next_gap = idle_len(in_gap_pct);
		if (next_gap > 0 || !more) begin
			in_valid <= 1'b0;
		end
	endtask

	task automatic send_bytes(logic [31:0] w, int n, bit ends_stream, bit more);
		for (int k = 0; k < n; k++) begin
			send_item(w[31 - 8 * k -: 8], ends_stream && k == n - 1, more || k < n - 1);
		end
	endtask

	task automatic send_text(string s, bit ends_stream, bit more);
		for (int k = 0; k < s.len(); k++) begin
			send_item(s[k], ends_stream && k == s.len() - 1, more || k < s.len() - 1);
		end
	endtask

	// all owed octets out, then let dropped-group work settle
	task automatic wait_drained();
		while (owed_octets.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register writes while idle; step is always written, mode when asked
	task automatic configure(bit wr_mode, logic mode_val, logic [6:0] step_val);
		wait_drained();
		if (wr_mode) begin
			cfg_we <= 1'b1;
			cfg_index <= rb85_pkg::REG_MODE;
			cfg_data <= {6'd0, mode_val};
			@(posedge clk);
			cur_mode = mode_val;
			clear_stream();
		end
		cfg_we <= 1'b1;
		cfg_index <= rb85_pkg::REG_STEP;
		cfg_data <= step_val;
		@(posedge clk);
		cur_step = step_val;
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// zero and all-ones groups, short final group, step 0 and 84
	task automatic test_encode_edges();
		in_gap_pct = 0;
		out_stall_pct = 0;
		configure(1'b1, rb85_pkg::MODE_ENCODE, 7'd0);
		send_bytes(32'h0000_0000, 4, 1'b0, 1'b1);
		send_bytes(32'hFFFF_FFFF, 4, 1'b0, 1'b1);
		send_bytes(32'hAB00_0000, 1, 1'b1, 1'b0);
		configure(1'b0, rb85_pkg::MODE_ENCODE, 7'd84);
		send_bytes(32'h1234_0000, 2, 1'b1, 1'b0);
	endtask

	// overflowing group, unknown characters, step above 84, dropped partial group
	task automatic test_decode_edges();
		in_gap_pct = 20;
		out_stall_pct = 30;
		configure(1'b1, rb85_pkg::MODE_DECODE, 7'd127);
		send_text("#####", 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		send_text("0aZ", 1'b0, 1'b1);
		send_text(".-x", 1'b1, 1'b0);
	endtask

	// random settings per phase; decode streams mostly whole groups, some cut or unterminated
	task automatic test_random_streams();
		int budget;
		int len;
		logic mode_val;
		bit wr_mode;
		logic [6:0] step_val;
		logic [7:0] v;
		bit ends_stream;
		while (n_sent < TOTAL_ITEMS) begin
			wr_mode = ($urandom_range(3) != 0);
			mode_val = wr_mode ? logic'($urandom_range(1)) : cur_mode;
			case ($urandom_range(5))
				0: step_val = 7'd0;
				1: step_val = 7'd84;
				2: step_val = 7'd85;
				3: step_val = 7'd127;
				default: step_val = 7'($urandom_range(127));
			endcase
			case ($urandom_range(2))
				0: in_gap_pct = 0;
				1: in_gap_pct = 25;
				default: in_gap_pct = 60;
			endcase
			case ($urandom_range(2))
				0: out_stall_pct = 0;
				1: out_stall_pct = 25;
				default: out_stall_pct = 60;
			endcase
			configure(wr_mode, mode_val, step_val);
			budget = $urandom_range(35, 15);
			if (budget > TOTAL_ITEMS - n_sent) begin
				budget = TOTAL_ITEMS - n_sent;
			end
			while (budget > 0) begin
				if (cur_mode == rb85_pkg::MODE_DECODE && $urandom_range(9) < 8) begin
					len = 5 * $urandom_range(3, 1);
				end else begin
					len = $urandom_range(12, 1);
				end
				if (len > budget) begin
					len = budget;
				end
				for (int j = 0; j < len; j++) begin
					if (cur_mode == rb85_pkg::MODE_DECODE && $urandom_range(19) != 0) begin
						v = z85_set[$urandom_range(84)];
					end else begin
						v = 8'($urandom_range(255));
					end
					ends_stream = (j == len - 1) && ($urandom_range(4) != 0);
					send_item(v, ends_stream, budget > 1);
					budget--;
				end
			end
		end
	endtask

	// receiver stall pattern
	always @(posedge clk) begin : stall_gen
		int len;
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			len = idle_len(out_stall_pct);
			if (len > 0) begin
				stall_left = len - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// compare every output transfer with the oldest owed octet
	always @(posedge clk) begin : octet_check
		rb85_pkg::out_item_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_octets.size() == 0) begin
				$error("out_value: nothing owed, got %02h (out_last %0b)",
					out_data.out_value, out_data.out_last);
				n_err++;
			end else begin
				due = owed_octets.pop_front();
				if (out_data.out_value !== due.out_value) begin
					$error("out_value: expected %02h, got %02h", due.out_value, out_data.out_value);
					n_err++;
				end
				if (out_data.out_last !== due.out_last) begin
					$error("out_last: expected %0b, got %0b", due.out_last, out_data.out_last);
					n_err++;
				end
				n_checked++;
			end
		end
	end

	// stop when no transfer or write happens for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STUCK_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encode_edges();
		test_decode_edges();
		test_random_streams();
		wait_drained();
		$display("run covered %0d input transfers and %0d checked outputs", n_sent, n_checked);
		$display("over %0d register settings in both modes, with and without idling", n_settings);
		if (n_err == 0 && owed_octets.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/rb85_pkg.sv
hw/rtl/rb85_front.sv
hw/rtl/rb85_conv.sv
hw/rtl/rb85_emit.sv
hw/rtl/rotating_base85_codec.sv
test/testbench.sv
